// ===== rtl/gb_pkg.sv =====
// shared constants, types and register codes for the separable gaussian blur
// no dependencies
package gb_pkg;

  localparam int DEF_MAX_RADIUS = 3;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_LANES      = 4;
  localparam int HEIGHT_CAP     = 1024;

  localparam int SAMPLE_W = 8;
  localparam int WEIGHT_W = 16;
  localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
  localparam int ACC_W    = 27;
  localparam int WSUM_W   = 19;
  localparam int REM_W    = 29;
  localparam int POS_W    = 10;
  localparam int ADDR_W   = 5;

  localparam logic [2:0] REG_RADIUS  = 3'd0;
  localparam logic [2:0] REG_WIDTH   = 3'd1;
  localparam logic [2:0] REG_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_CHANNEL = 3'd3;
  localparam logic [2:0] REG_WEIGHT0 = 3'd4;
  localparam logic [2:0] REG_WEIGHT1 = 3'd5;
  localparam logic [2:0] REG_WEIGHT2 = 3'd6;
  localparam logic [2:0] REG_WEIGHT3 = 3'd7;

  typedef struct packed {
    logic clear;
    logic mul;
    logic add;
    logic load;
    logic step;
  } lane_ctrl_t;

endpackage

// ===== rtl/gb_if.sv =====
// stream interfaces for pixel beats in and filtered pixel beats out
// depends on gb_pkg
interface gb_pix_if;
  logic                          valid;
  logic                          ready;
  logic [gb_pkg::SAMPLE_W-1:0]   sample_c0;
  logic [gb_pkg::SAMPLE_W-1:0]   sample_c1;
  logic [gb_pkg::SAMPLE_W-1:0]   sample_c2;
  logic [gb_pkg::SAMPLE_W-1:0]   sample_c3;
  modport source(output valid, sample_c0, sample_c1, sample_c2, sample_c3, input ready);
  modport sink(input valid, sample_c0, sample_c1, sample_c2, sample_c3, output ready);
endinterface

interface gb_res_if;
  logic                          valid;
  logic                          ready;
  logic [gb_pkg::POS_W-1:0]      pos_x;
  logic [gb_pkg::POS_W-1:0]      pos_y;
  logic [gb_pkg::SAMPLE_W-1:0]   result_c0;
  logic [gb_pkg::SAMPLE_W-1:0]   result_c1;
  logic [gb_pkg::SAMPLE_W-1:0]   result_c2;
  logic [gb_pkg::SAMPLE_W-1:0]   result_c3;
  logic                          frame_end;
  modport source(output valid, pos_x, pos_y, result_c0, result_c1, result_c2, result_c3,
                 frame_end, input ready);
  modport sink(input valid, pos_x, pos_y, result_c0, result_c1, result_c2, result_c3,
               frame_end, output ready);
endinterface

// ===== rtl/gb_line_buf.sv =====
// line buffers: one row memory per stored image row, read and written at one column
// depends on nothing
module gb_line_buf #(
  parameter int ROWS  = 6,
  parameter int DEPTH = 1024,
  parameter int DW    = 32,
  localparam int AW   = $clog2(DEPTH),
  localparam int RW   = $clog2(ROWS)
) (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [AW-1:0]           addr,
  input  logic                    wr_en,
  input  logic [RW-1:0]           wr_row,
  input  logic [DW-1:0]           wr_data,
  output logic [ROWS-1:0][DW-1:0] rd_data
);

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    logic [DW-1:0] mem [DEPTH];
    always_ff @(posedge clk) begin
      if (wr_en && wr_row == RW'(r)) begin
        mem[addr] <= wr_data;
      end
      if (rd_en) begin
        rd_data[r] <= mem[addr];
      end
    end
  end

endmodule

// ===== rtl/gb_lane.sv =====
// one channel lane: shared multiply-accumulate and bit-serial rounding divider
// depends on gb_pkg
module gb_lane (
  input  logic                          clk,
  input  gb_pkg::lane_ctrl_t            ctrl,
  input  logic [gb_pkg::SAMPLE_W-1:0]   tap,
  input  logic [gb_pkg::WEIGHT_W-1:0]   weight,
  input  logic [gb_pkg::WSUM_W-1:0]     wsum,
  output logic [gb_pkg::SAMPLE_W-1:0]   quot
);

  logic [gb_pkg::PROD_W-1:0]   prod;
  logic [gb_pkg::ACC_W-1:0]    acc;
  logic [gb_pkg::REM_W-1:0]    rem;
  logic [gb_pkg::REM_W-1:0]    dsh;
  logic [gb_pkg::SAMPLE_W-1:0] q;

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod <= gb_pkg::PROD_W'(weight) * gb_pkg::PROD_W'(tap);
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.add) begin
      acc <= acc + gb_pkg::ACC_W'(prod);
    end
    if (ctrl.load) begin
      rem <= gb_pkg::REM_W'({acc, 1'b0}) + gb_pkg::REM_W'(wsum);
      dsh <= gb_pkg::REM_W'({wsum, 1'b0}) << (gb_pkg::SAMPLE_W - 1);
      q   <= '0;
    end else if (ctrl.step) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        q   <= {q[gb_pkg::SAMPLE_W-2:0], 1'b1};
      end else begin
        q   <= {q[gb_pkg::SAMPLE_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  assign quot = q;

endmodule

// ===== rtl/separable_gaussian_blur_core.sv =====
// Separable gaussian blur over a raster pixel stream, up to four 8-bit channels in parallel
// lanes, one multiplier and one bit-serial divider per lane shared by the vertical and
// horizontal passes. A pixel in the top 2r rows is only written to the line buffers; any
// other pixel runs the vertical pass, and also the horizontal pass when it yields a result
// (r = live radius); the taps go one per cycle through each lane's multiplier and each pass
// needs 8 divide steps. A finished result waits in an output register while the next pixel
// is taken. Depends on gb_pkg, gb_if, gb_line_buf and gb_lane.
module separable_gaussian_blur_core #(
  parameter int MAX_RADIUS = gb_pkg::DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = gb_pkg::DEF_MAX_WIDTH,
  parameter int LANES      = gb_pkg::DEF_LANES
) (
  input  logic                      clk,
  input  logic                      rst,
  gb_pix_if.sink                    pixel,
  gb_res_if.source                  result,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [gb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int LINE_ROWS = 2 * MAX_RADIUS;
  localparam int WIN_LEN   = 2 * MAX_RADIUS + 1;
  localparam int LW        = LANES * gb_pkg::SAMPLE_W;
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int WL        = CW + 1;
  localparam int RPW       = $clog2(LINE_ROWS);
  localparam int WIW       = $clog2(WIN_LEN);
  localparam int TW        = (WIW > 3) ? WIW : 3;
  localparam int SW        = gb_pkg::SAMPLE_W;

  typedef enum logic [2:0] {S_IDLE, S_MAC, S_FLUSH, S_LOAD, S_DIV, S_SHIFT, S_OUT} state_t;

  state_t state;

  logic [1:0]                 cfg_radius;
  logic [10:0]                cfg_width;
  logic [10:0]                cfg_height;
  logic [2:0]                 cfg_chan;
  logic [3:0][gb_pkg::WEIGHT_W-1:0] cfg_weight;

  logic [CW-1:0]              col;
  logic [gb_pkg::POS_W-1:0]   row;
  logic [RPW-1:0]             row_ptr;
  logic [CW-1:0]              col_next;
  logic [gb_pkg::POS_W-1:0]   row_next;
  logic [RPW-1:0]             row_ptr_next;

  logic [LW-1:0]              pix_reg;
  logic [WIN_LEN-1:0][LW-1:0] win;
  logic [TW-1:0]              cnt;
  logic                       hpass;
  logic                       vok;
  logic                       emit;
  logic                       add_pend;

  logic                       res_valid;
  logic [gb_pkg::POS_W-1:0]   res_x;
  logic [gb_pkg::POS_W-1:0]   res_y;
  logic [3:0][SW-1:0]         res_c;
  logic                       res_end;

  logic [1:0]                 r_live;
  logic [2:0]                 two_r;
  logic [WL-1:0]              w_lim;
  logic [10:0]                h_lim;
  logic [gb_pkg::WSUM_W-1:0]  wsum;
  logic                       accept;
  logic                       cfg_wr;
  logic [RPW-1:0]             rowidx;
  logic [2:0]                 tap_dist;
  logic [gb_pkg::WEIGHT_W-1:0] tap_weight;
  logic [LINE_ROWS-1:0][LW-1:0] rd_data;
  logic [LANES-1:0][SW-1:0]   lane_q;
  logic [LW-1:0]              vres;
  logic [3:0][SW-1:0]         out_c;
  gb_pkg::lane_ctrl_t         lctrl;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_radius <= 2'd1;
      cfg_width  <= 11'd1024;
      cfg_height <= 11'd1024;
      cfg_chan   <= 3'd1;
      cfg_weight <= {16'd0, 16'd0, 16'd0, 16'hffff};
    end else if (cfg_wr) begin
      case (paddr[4:2])
        gb_pkg::REG_RADIUS:  cfg_radius    <= pwdata[1:0];
        gb_pkg::REG_WIDTH:   cfg_width     <= pwdata[10:0];
        gb_pkg::REG_HEIGHT:  cfg_height    <= pwdata[10:0];
        gb_pkg::REG_CHANNEL: cfg_chan      <= pwdata[2:0];
        gb_pkg::REG_WEIGHT0: cfg_weight[0] <= pwdata[15:0];
        gb_pkg::REG_WEIGHT1: cfg_weight[1] <= pwdata[15:0];
        gb_pkg::REG_WEIGHT2: cfg_weight[2] <= pwdata[15:0];
        gb_pkg::REG_WEIGHT3: cfg_weight[3] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      gb_pkg::REG_RADIUS:  prdata = 32'(cfg_radius);
      gb_pkg::REG_WIDTH:   prdata = 32'(cfg_width);
      gb_pkg::REG_HEIGHT:  prdata = 32'(cfg_height);
      gb_pkg::REG_CHANNEL: prdata = 32'(cfg_chan);
      gb_pkg::REG_WEIGHT0: prdata = 32'(cfg_weight[0]);
      gb_pkg::REG_WEIGHT1: prdata = 32'(cfg_weight[1]);
      gb_pkg::REG_WEIGHT2: prdata = 32'(cfg_weight[2]);
      gb_pkg::REG_WEIGHT3: prdata = 32'(cfg_weight[3]);
      default:             prdata = '0;
    endcase
  end

  // live geometry and weight sum
  always_comb begin
    r_live = (int'(cfg_radius) > MAX_RADIUS) ? 2'(MAX_RADIUS) : cfg_radius;
    two_r  = {r_live, 1'b0};
    if (cfg_width == 11'd0) begin
      w_lim = WL'(1);
    end else if (int'(cfg_width) > MAX_WIDTH) begin
      w_lim = WL'(MAX_WIDTH);
    end else begin
      w_lim = WL'(cfg_width);
    end
    if (cfg_height == 11'd0) begin
      h_lim = 11'd1;
    end else if (int'(cfg_height) > gb_pkg::HEIGHT_CAP) begin
      h_lim = 11'(gb_pkg::HEIGHT_CAP);
    end else begin
      h_lim = cfg_height;
    end
    wsum = gb_pkg::WSUM_W'(cfg_weight[0])
         + ((r_live >= 2'd1) ? gb_pkg::WSUM_W'({cfg_weight[1], 1'b0}) : gb_pkg::WSUM_W'(0))
         + ((r_live >= 2'd2) ? gb_pkg::WSUM_W'({cfg_weight[2], 1'b0}) : gb_pkg::WSUM_W'(0))
         + ((r_live >= 2'd3) ? gb_pkg::WSUM_W'({cfg_weight[3], 1'b0}) : gb_pkg::WSUM_W'(0));
  end

  // raster position after this pixel
  always_comb begin
    if (WL'(col) + WL'(1) >= w_lim) begin
      col_next = '0;
      if (11'(row) + 11'd1 >= h_lim) begin
        row_next     = '0;
        row_ptr_next = '0;
      end else begin
        row_next     = row + gb_pkg::POS_W'(1);
        row_ptr_next = (int'(row_ptr) == LINE_ROWS - 1) ? '0 : row_ptr + RPW'(1);
      end
    end else begin
      col_next     = col + CW'(1);
      row_next     = row;
      row_ptr_next = row_ptr;
    end
  end

  // tap select
  always_comb begin
    if (int'(row_ptr) >= int'(cnt)) begin
      rowidx = RPW'(int'(row_ptr) - int'(cnt));
    end else begin
      rowidx = RPW'(int'(row_ptr) + LINE_ROWS - int'(cnt));
    end
    tap_dist   = (3'(cnt) > 3'(r_live)) ? 3'(cnt) - 3'(r_live) : 3'(r_live) - 3'(cnt);
    tap_weight = cfg_weight[tap_dist[1:0]];
  end

  assign accept       = pixel.valid && pixel.ready;
  assign pixel.ready  = (state == S_IDLE);
  assign lctrl.clear  = accept || (state == S_SHIFT);
  assign lctrl.mul    = (state == S_MAC);
  assign lctrl.add    = add_pend;
  assign lctrl.load   = (state == S_LOAD);
  assign lctrl.step   = (state == S_DIV);

  gb_line_buf #(
    .ROWS  (LINE_ROWS),
    .DEPTH (MAX_WIDTH),
    .DW    (LW)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .addr    (col),
    .wr_en   (state == S_SHIFT),
    .wr_row  (row_ptr),
    .wr_data (pix_reg),
    .rd_data (rd_data)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [SW-1:0] tap;
    always_comb begin
      if (hpass) begin
        tap = win[cnt[WIW-1:0]][l*SW +: SW];
      end else if (cnt == '0) begin
        tap = pix_reg[l*SW +: SW];
      end else begin
        tap = rd_data[rowidx][l*SW +: SW];
      end
    end
    gb_lane u_lane (
      .clk    (clk),
      .ctrl   (lctrl),
      .tap    (tap),
      .weight (tap_weight),
      .wsum   (wsum),
      .quot   (lane_q[l])
    );
    assign vres[l*SW +: SW] = (vok && wsum != '0) ? lane_q[l] : '0;
  end

  // merge lanes into the result channels
  for (genvar l = 0; l < 4; l++) begin : g_merge
    if (l < LANES) begin : g_live
      assign out_c[l] = (wsum != '0 && l < int'(cfg_chan)) ? lane_q[l] : '0;
    end else begin : g_dead
      assign out_c[l] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      col       <= '0;
      row       <= '0;
      row_ptr   <= '0;
      win       <= '0;
      cnt       <= '0;
      hpass     <= 1'b0;
      vok       <= 1'b0;
      emit      <= 1'b0;
      add_pend  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      add_pend <= (state == S_MAC);
      if (res_valid && result.ready && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pix_reg <= LW'({pixel.sample_c3, pixel.sample_c2, pixel.sample_c1,
                            pixel.sample_c0});
            hpass   <= 1'b0;
            cnt     <= '0;
            vok     <= (row >= gb_pkg::POS_W'(two_r));
            emit    <= (WL'(col) >= WL'(two_r)) && (row >= gb_pkg::POS_W'(two_r))
                       && (WL'(col) < w_lim) && (11'(row) < h_lim);
            state   <= (row >= gb_pkg::POS_W'(two_r)) ? S_MAC : S_SHIFT;
          end
        end
        S_MAC: begin
          if (cnt == TW'(two_r)) begin
            cnt   <= '0;
            state <= S_FLUSH;
          end else begin
            cnt <= cnt + TW'(1);
          end
        end
        S_FLUSH: state <= S_LOAD;
        S_LOAD:  state <= S_DIV;
        S_DIV: begin
          if (cnt == TW'(SW - 1)) begin
            cnt   <= '0;
            state <= hpass ? S_OUT : S_SHIFT;
          end else begin
            cnt <= cnt + TW'(1);
          end
        end
        S_SHIFT: begin
          win <= {win[WIN_LEN-2:0], vres};
          if (emit) begin
            hpass <= 1'b1;
            cnt   <= '0;
            state <= S_MAC;
          end else begin
            col     <= col_next;
            row     <= row_next;
            row_ptr <= row_ptr_next;
            state   <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            res_x     <= gb_pkg::POS_W'(col - CW'(r_live));
            res_y     <= row - gb_pkg::POS_W'(r_live);
            res_c     <= out_c;
            res_end   <= (WL'(col) == w_lim - WL'(1)) && (11'(row) == h_lim - 11'd1);
            col       <= col_next;
            row       <= row_next;
            row_ptr   <= row_ptr_next;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid     = res_valid;
  assign result.pos_x     = res_x;
  assign result.pos_y     = res_y;
  assign result.result_c0 = res_c[0];
  assign result.result_c1 = res_c[1];
  assign result.result_c2 = res_c[2];
  assign result.result_c3 = res_c[3];
  assign result.frame_end = res_end;

  a_row_ptr_range: assert property (@(posedge clk) disable iff (rst)
    int'(row_ptr) < LINE_ROWS)
    else $error("line buffer row pointer out of range");

  a_frame_end_pos: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.frame_end |->
      result.pos_x == gb_pkg::POS_W'(w_lim - WL'(1) - WL'(r_live)))
    else $error("frame end flagged away from the last interior column");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("pixel accepted but sequencer stayed idle");

endmodule
